FILE: rtl/cse_pkg.sv
`default_nettype none
package cse_pkg;

  // Storage limits of the sample memory.
  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Row count and its square, as seen inside the datapath.
  localparam int ROW_W = $clog2(MAX_ROWS) + 1;
  localparam int NN_W  = 2 * ROW_W;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 32;
  localparam int ENTRY_W  = 64;
  localparam int IDX_W    = 3;
  localparam int ROWREG_W = 9;
  localparam int COLREG_W = 4;
  localparam int CFGIDX_W = 2;

  // Covariance sums, dispersion sums and the shared multiplier.
  localparam int CSUM_W = ENTRY_W + ROW_W;
  localparam int WIDE_W = 2 * ENTRY_W + 6 + 2 * ROW_W;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int WQ_W   = 33;
  localparam int COV_AW = 2 * IDX_W;

  // Configuration register indexes.
  localparam logic [CFGIDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFGIDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

endpackage
`default_nettype wire

FILE: rtl/covariance_shrinkage_estimator_unit.sv
`default_nettype none
// Loading: one sample beat per cycle; the beat that completes the n by p matrix starts a run.
// A run works on one shared 34x34 multiplier and radix-2 shift-subtract divide steps; the
// weight divide runs only when the sum D is nonzero and B < D * n * n. Result beats then
// leave one at a time, each built only after the receiver has taken the one before. No
// sample is taken during a run or its result beats, while a register write is offered,
// or the cycle after a register write. Reset (synchronous, rst_n low) sets n and p to
// one and empties the load count; the sample and covariance memories are not cleared.
module covariance_shrinkage_estimator_unit (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  signed [cse_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic signed [cse_pkg::ENTRY_W-1:0]       out_entry_value,
  output logic        [cse_pkg::IDX_W-1:0]         out_row_index,
  output logic        [cse_pkg::IDX_W-1:0]         out_col_index,
  output logic                                     out_last_entry,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire         [cse_pkg::CFGIDX_W-1:0]      cfg_index,
  input  wire         [cse_pkg::ROWREG_W-1:0]      cfg_data
);

  localparam int DCNT_W = $clog2(cse_pkg::CSUM_W + 1);

  typedef enum logic [5:0] {
    ST_LOAD, ST_C_CLR, ST_C_RD, ST_C_MUL, ST_C_ACC, ST_C_DSET, ST_C_DIV, ST_C_WR,
    ST_M_SET, ST_M_DIV, ST_M_END, ST_B_S0, ST_B_S1, ST_B_RD, ST_B_MUL, ST_B_DIF,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_W_SET, ST_W_MUL, ST_W_CHK, ST_W_DIV,
    ST_E_S0, ST_E_S1, ST_E_M0, ST_E_M1, ST_E_M2, ST_E_OUT
  } state_t;

  state_t state_r;

  // Configuration and derived sizes.
  logic [cse_pkg::ROWREG_W-1:0] row_count_r;
  logic [cse_pkg::COLREG_W-1:0] col_count_r;
  logic [cse_pkg::ROW_W-1:0]    n_eff;
  logic [cse_pkg::COLREG_W-1:0] p_eff;
  logic [cse_pkg::CNT_W-1:0]    tot_r;
  logic [cse_pkg::NN_W-1:0]     nn_r;
  logic                         cfg_dly_r;
  logic [cse_pkg::CNT_W-1:0]    cnt_r;

  // Loop counters.
  logic [cse_pkg::IDX_W-1:0]  i_r, j_r;
  logic [cse_pkg::ROW_W-1:0]  k_r;
  logic [cse_pkg::ADDR_W-1:0] kb_r;
  logic                       k_last, j_last, ij_last;

  // Memories and their read registers.
  logic signed [cse_pkg::SAMPLE_W-1:0] sample_mem [0:cse_pkg::STORE_DEPTH-1];
  logic signed [cse_pkg::ENTRY_W-1:0]  cov_mem [0:(1 << cse_pkg::COV_AW)-1];
  logic signed [cse_pkg::SAMPLE_W-1:0] rd_a_r, rd_b_r;
  logic signed [cse_pkg::ENTRY_W-1:0]  cov_rd_r;
  logic [cse_pkg::ADDR_W-1:0]          addr_a, addr_b;
  logic [cse_pkg::COV_AW-1:0]          cov_addr;
  logic                                cov_we;
  logic signed [cse_pkg::ENTRY_W-1:0]  cov_wd;

  // Datapath registers.
  logic signed [cse_pkg::PROD_W-1:0] prod_r;
  logic signed [cse_pkg::CSUM_W-1:0] acc_r;
  logic [cse_pkg::CSUM_W-1:0]        tr_r;
  logic [cse_pkg::CSUM_W-1:0]        div_n_r;
  logic [cse_pkg::ROW_W-1:0]         div_rem_r;
  logic [cse_pkg::ROW_W-1:0]         div_d_r;
  logic [DCNT_W-1:0]                 dcnt_r;
  logic                              neg_r;
  logic signed [cse_pkg::ENTRY_W-1:0] m_r, s_r;
  logic [cse_pkg::ENTRY_W-1:0]       mg_r;
  logic                              sq_b_r;
  logic [cse_pkg::WIDE_W-1:0]        dsum_r, bsum_r, den_r, dsh_r, rem_r;
  logic [cse_pkg::NN_W-1:0]          nn_sh_r;
  logic [cse_pkg::WQ_W-1:0]          wq_r;
  logic [cse_pkg::WQ_W-1:0]          tmp_r;

  // Combinational helpers.
  logic signed [cse_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cse_pkg::PROD_W-1:0] prod_full;
  logic [cse_pkg::ROW_W:0]           dv_t;
  logic                              dv_ge;
  logic [cse_pkg::WIDE_W-1:0]        sq_add, sq_sum;
  logic [cse_pkg::WIDE_W:0]          w_r2;
  logic                              w_ge;
  logic signed [cse_pkg::ENTRY_W-1:0] mdiag;
  logic signed [cse_pkg::ENTRY_W:0]  dif_cs, dif_bd, dif_e;
  logic [cse_pkg::ENTRY_W-1:0]       q64, delta;
  logic                              in_fire, out_fire, cfg_fire;

  function automatic logic [cse_pkg::ENTRY_W-1:0] mag65(input logic signed [cse_pkg::ENTRY_W:0] v);
    logic signed [cse_pkg::ENTRY_W:0] a;
    a = v[cse_pkg::ENTRY_W] ? -v : v;
    return a[cse_pkg::ENTRY_W-1:0];
  endfunction

  // Effective sizes with out-of-range values clamped.
  always_comb begin
    if (row_count_r == '0) begin
      n_eff = cse_pkg::ROW_W'(1);
    end else if (int'(row_count_r) > cse_pkg::MAX_ROWS) begin
      n_eff = cse_pkg::ROW_W'(cse_pkg::MAX_ROWS);
    end else begin
      n_eff = cse_pkg::ROW_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      p_eff = cse_pkg::COLREG_W'(1);
    end else if (int'(col_count_r) > cse_pkg::MAX_COLS) begin
      p_eff = cse_pkg::COLREG_W'(cse_pkg::MAX_COLS);
    end else begin
      p_eff = col_count_r;
    end
  end

  assign in_ready  = (state_r == ST_LOAD) && !cfg_dly_r && !cfg_valid;
  assign cfg_ready = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign k_last  = (k_r == n_eff - cse_pkg::ROW_W'(1));
  assign j_last  = ({1'b0, j_r} == p_eff - cse_pkg::COLREG_W'(1));
  assign ij_last = j_last && ({1'b0, i_r} == p_eff - cse_pkg::COLREG_W'(1));

  assign addr_a   = kb_r + cse_pkg::ADDR_W'(i_r);
  assign addr_b   = kb_r + cse_pkg::ADDR_W'(j_r);
  assign cov_addr = {i_r, j_r};
  assign mdiag    = (i_r == j_r) ? m_r : '0;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      ST_C_MUL, ST_B_MUL: begin
        mul_a = cse_pkg::MUL_W'(rd_a_r);
        mul_b = cse_pkg::MUL_W'(rd_b_r);
      end
      ST_SQ0: begin
        mul_a = $signed({2'b00, mg_r[31:0]});
        mul_b = $signed({2'b00, mg_r[31:0]});
      end
      ST_SQ1: begin
        mul_a = $signed({2'b00, mg_r[63:32]});
        mul_b = $signed({2'b00, mg_r[31:0]});
      end
      ST_SQ2: begin
        mul_a = $signed({2'b00, mg_r[63:32]});
        mul_b = $signed({2'b00, mg_r[63:32]});
      end
      ST_E_M0: begin
        mul_a = $signed({2'b00, mg_r[31:0]});
        mul_b = $signed({1'b0, wq_r});
      end
      ST_E_M1: begin
        mul_a = $signed({2'b00, mg_r[63:32]});
        mul_b = $signed({1'b0, wq_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_full = mul_a * mul_b;

  // Square accumulation: partial products land at their bit positions.
  always_comb begin
    unique case (state_r)
      ST_SQ1:  sq_add = cse_pkg::WIDE_W'(prod_r[63:0]);
      ST_SQ2:  sq_add = cse_pkg::WIDE_W'(prod_r[63:0]) << 33;
      ST_SQ3:  sq_add = cse_pkg::WIDE_W'(prod_r[63:0]) << 64;
      default: sq_add = '0;
    endcase
  end
  assign sq_sum = (sq_b_r ? bsum_r : dsum_r) + sq_add;

  // Radix-2 step of the small divider.
  assign dv_t  = {div_rem_r, div_n_r[cse_pkg::CSUM_W-1]};
  assign dv_ge = (dv_t >= {1'b0, div_d_r});

  // Radix-2 step of the weight divider.
  assign w_r2 = {rem_r, 1'b0};
  assign w_ge = (w_r2 >= {1'b0, den_r});

  // Differences that feed magnitudes.
  assign dif_cs = {cov_rd_r[63], cov_rd_r} - {mdiag[63], mdiag};
  assign dif_bd = {prod_r[63], prod_r[63:0]} - {s_r[63], s_r};
  assign dif_e  = {mdiag[63], mdiag} - {cov_rd_r[63], cov_rd_r};

  assign q64    = neg_r ? (~div_n_r[63:0] + 64'd1) : div_n_r[63:0];
  assign cov_we = (state_r == ST_C_WR);
  assign cov_wd = $signed(q64);
  assign delta  = prod_r[63:0] + cse_pkg::ENTRY_W'(tmp_r);

  // Sample memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_mem[cnt_r[cse_pkg::ADDR_W-1:0]] <= in_sample;
    end
    rd_a_r <= sample_mem[addr_a];
    rd_b_r <= sample_mem[addr_b];
  end

  // Covariance memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cov_we) begin
      cov_mem[cov_addr] <= cov_wd;
    end
    cov_rd_r <= cov_mem[cov_addr];
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      row_count_r <= cse_pkg::ROWREG_W'(1);
      col_count_r <= cse_pkg::COLREG_W'(1);
      tot_r       <= cse_pkg::CNT_W'(1);
      nn_r        <= cse_pkg::NN_W'(1);
      cfg_dly_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid   <= 1'b0;
    end else begin
      tot_r     <= cse_pkg::CNT_W'(n_eff) * cse_pkg::CNT_W'(p_eff);
      nn_r      <= cse_pkg::NN_W'(n_eff) * cse_pkg::NN_W'(n_eff);
      cfg_dly_r <= cfg_fire;
      prod_r    <= prod_full;

      unique case (state_r)
        ST_LOAD: begin
          if (cfg_fire) begin
            if (cfg_index == cse_pkg::CFG_ROW_COUNT) begin
              row_count_r <= cfg_data;
              cnt_r       <= '0;
            end else if (cfg_index == cse_pkg::CFG_COLUMN_COUNT) begin
              col_count_r <= cfg_data[cse_pkg::COLREG_W-1:0];
              cnt_r       <= '0;
            end
          end else if (in_fire) begin
            if (cnt_r + cse_pkg::CNT_W'(1) == tot_r) begin
              cnt_r   <= '0;
              i_r     <= '0;
              j_r     <= '0;
              tr_r    <= '0;
              state_r <= ST_C_CLR;
            end else begin
              cnt_r <= cnt_r + cse_pkg::CNT_W'(1);
            end
          end
        end

        // Covariance sums, one product per pass.
        ST_C_CLR: begin
          acc_r   <= '0;
          k_r     <= '0;
          kb_r    <= '0;
          state_r <= ST_C_RD;
        end
        ST_C_RD:  state_r <= ST_C_MUL;
        ST_C_MUL: state_r <= ST_C_ACC;
        ST_C_ACC: begin
          acc_r <= acc_r + cse_pkg::CSUM_W'(prod_r);
          if (k_last) begin
            state_r <= ST_C_DSET;
          end else begin
            k_r     <= k_r + cse_pkg::ROW_W'(1);
            kb_r    <= kb_r + cse_pkg::ADDR_W'(p_eff);
            state_r <= ST_C_RD;
          end
        end
        ST_C_DSET: begin
          neg_r     <= acc_r[cse_pkg::CSUM_W-1];
          div_n_r   <= acc_r[cse_pkg::CSUM_W-1] ? -acc_r : acc_r;
          div_rem_r <= '0;
          div_d_r   <= n_eff;
          dcnt_r    <= '0;
          state_r   <= ST_C_DIV;
        end
        ST_C_DIV, ST_M_DIV: begin
          div_n_r   <= {div_n_r[cse_pkg::CSUM_W-2:0], dv_ge};
          div_rem_r <= dv_ge ? cse_pkg::ROW_W'(dv_t - {1'b0, div_d_r})
                             : dv_t[cse_pkg::ROW_W-1:0];
          dcnt_r    <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(cse_pkg::CSUM_W - 1)) begin
            state_r <= (state_r == ST_C_DIV) ? ST_C_WR : ST_M_END;
          end
        end
        ST_C_WR: begin
          if (i_r == j_r) begin
            tr_r <= tr_r + cse_pkg::CSUM_W'(q64);
          end
          if (ij_last) begin
            state_r <= ST_M_SET;
          end else begin
            j_r     <= j_last ? '0 : j_r + cse_pkg::IDX_W'(1);
            i_r     <= j_last ? i_r + cse_pkg::IDX_W'(1) : i_r;
            state_r <= ST_C_CLR;
          end
        end

        // Target scale from the trace.
        ST_M_SET: begin
          neg_r     <= 1'b0;
          div_n_r   <= tr_r;
          div_rem_r <= '0;
          div_d_r   <= cse_pkg::ROW_W'(p_eff);
          dcnt_r    <= '0;
          state_r   <= ST_M_DIV;
        end
        ST_M_END: begin
          m_r     <= $signed(div_n_r[63:0]);
          i_r     <= '0;
          j_r     <= '0;
          dsum_r  <= '0;
          bsum_r  <= '0;
          state_r <= ST_B_S0;
        end

        // Dispersion sums over entries and over observations.
        ST_B_S0: state_r <= ST_B_S1;
        ST_B_S1: begin
          s_r     <= cov_rd_r;
          mg_r    <= mag65(dif_cs);
          sq_b_r  <= 1'b0;
          state_r <= ST_SQ0;
        end
        ST_B_RD:  state_r <= ST_B_MUL;
        ST_B_MUL: state_r <= ST_B_DIF;
        ST_B_DIF: begin
          mg_r    <= mag65(dif_bd);
          sq_b_r  <= 1'b1;
          state_r <= ST_SQ0;
        end
        ST_SQ0: state_r <= ST_SQ1;
        ST_SQ1, ST_SQ2: begin
          if (sq_b_r) begin
            bsum_r <= sq_sum;
          end else begin
            dsum_r <= sq_sum;
          end
          state_r <= (state_r == ST_SQ1) ? ST_SQ2 : ST_SQ3;
        end
        ST_SQ3: begin
          if (sq_b_r) begin
            bsum_r <= sq_sum;
          end else begin
            dsum_r <= sq_sum;
          end
          if (!sq_b_r) begin
            k_r     <= '0;
            kb_r    <= '0;
            state_r <= ST_B_RD;
          end else if (!k_last) begin
            k_r     <= k_r + cse_pkg::ROW_W'(1);
            kb_r    <= kb_r + cse_pkg::ADDR_W'(p_eff);
            state_r <= ST_B_RD;
          end else if (ij_last) begin
            state_r <= ST_W_SET;
          end else begin
            j_r     <= j_last ? '0 : j_r + cse_pkg::IDX_W'(1);
            i_r     <= j_last ? i_r + cse_pkg::IDX_W'(1) : i_r;
            state_r <= ST_B_S0;
          end
        end

        // Shrink weight: den = D * n * n, then B / den as a 33-bit value with 32 fraction bits.
        ST_W_SET: begin
          dsh_r   <= dsum_r;
          den_r   <= '0;
          nn_sh_r <= nn_r;
          dcnt_r  <= '0;
          state_r <= ST_W_MUL;
        end
        ST_W_MUL: begin
          if (nn_sh_r[0]) begin
            den_r <= den_r + dsh_r;
          end
          dsh_r   <= dsh_r << 1;
          nn_sh_r <= nn_sh_r >> 1;
          dcnt_r  <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(cse_pkg::NN_W - 1)) begin
            state_r <= ST_W_CHK;
          end
        end
        ST_W_CHK: begin
          i_r <= '0;
          j_r <= '0;
          if (dsum_r == '0) begin
            wq_r    <= '0;
            state_r <= ST_E_S0;
          end else if (bsum_r >= den_r) begin
            wq_r    <= cse_pkg::WQ_W'(1) << 32;
            state_r <= ST_E_S0;
          end else begin
            wq_r    <= '0;
            rem_r   <= bsum_r;
            dcnt_r  <= '0;
            state_r <= ST_W_DIV;
          end
        end
        ST_W_DIV: begin
          rem_r  <= w_ge ? cse_pkg::WIDE_W'(w_r2 - {1'b0, den_r})
                         : w_r2[cse_pkg::WIDE_W-1:0];
          wq_r   <= {wq_r[cse_pkg::WQ_W-2:0], w_ge};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(31)) begin
            state_r <= ST_E_S0;
          end
        end

        // Result beats.
        ST_E_S0: state_r <= ST_E_S1;
        ST_E_S1: begin
          s_r     <= cov_rd_r;
          neg_r   <= dif_e[cse_pkg::ENTRY_W];
          mg_r    <= mag65(dif_e);
          state_r <= ST_E_M0;
        end
        ST_E_M0: state_r <= ST_E_M1;
        ST_E_M1: begin
          tmp_r   <= prod_r[64:32];
          state_r <= ST_E_M2;
        end
        ST_E_M2: begin
          out_entry_value <= neg_r ? s_r - $signed(delta) : s_r + $signed(delta);
          out_row_index   <= i_r;
          out_col_index   <= j_r;
          out_last_entry  <= ij_last;
          out_valid       <= 1'b1;
          state_r         <= ST_E_OUT;
        end
        ST_E_OUT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            if (ij_last) begin
              state_r <= ST_LOAD;
            end else begin
              j_r     <= j_last ? '0 : j_r + cse_pkg::IDX_W'(1);
              i_r     <= j_last ? i_r + cse_pkg::IDX_W'(1) : i_r;
              state_r <= ST_E_S0;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire
